// ===== rtl/cht_pkg.sv =====
package cht_pkg;

  localparam int unsigned DefTableSize = 16;
  localparam int unsigned DefKeyMax    = 16;
  localparam int unsigned DefSpillSize = 16;

  // operation codes
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_SEARCH = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;
  localparam logic [1:0] OP_ALIAS  = 2'd3;  // acts as search

  // result codes
  localparam logic [2:0] STAT_INSERTED  = 3'd0;
  localparam logic [2:0] STAT_FOUND     = 3'd1;
  localparam logic [2:0] STAT_NOT_FOUND = 3'd2;
  localparam logic [2:0] STAT_DELETED   = 3'd3;
  localparam logic [2:0] STAT_FULL      = 3'd4;
  localparam logic [2:0] STAT_TOO_LONG  = 3'd5;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] key_char;
    logic       last_char;
  } cht_in_t;

  typedef struct packed {
    logic [2:0] status;
    logic [3:0] bucket;
  } cht_out_t;

endpackage

// ===== rtl/chained_hash_table.sv =====
// chained hash table with a shared overflow area
// keys stream in on the input channel one character per transfer; the
// transfer with last_char set also carries the opcode (insert, search,
// delete, code three acts as search) and triggers the table operation
// the output channel returns one transfer per key: status and bucket
// characters of a key are taken one per cycle; the bucket is kept as a
// running residue (table lookup plus one compare and subtract per character)
// the final character starts the operation and the input stays stalled
// until the result is registered
// operation steps: read the primary entry, compare each entry character by
// character while they match, follow the chain one step at a time, copy
// the key, walk each entry to the chain tail on insert, register the
// result; all steps go through synchronous memories with one read and one
// write port
// after reset a clearing pass marks all buckets empty; no input is taken
// during it
// a held result waits in the output register while the next key streams
// in; only the completion of the next operation waits on out_ready_i
module chained_hash_table #(
  parameter int unsigned TABLE_SIZE = cht_pkg::DefTableSize,
  parameter int unsigned KEY_MAX    = cht_pkg::DefKeyMax,
  parameter int unsigned SPILL_SIZE = cht_pkg::DefSpillSize
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  cht_pkg::cht_in_t   in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output cht_pkg::cht_out_t  out_data_o
);

  localparam int unsigned BKT_W = $clog2(TABLE_SIZE);
  localparam int unsigned KI_W  = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
  localparam int unsigned LEN_W = $clog2(KEY_MAX + 1);
  localparam int unsigned LNK_W = $clog2(SPILL_SIZE + 1);
  localparam int unsigned SP_W  = (SPILL_SIZE > 1) ? $clog2(SPILL_SIZE) : 1;
  localparam int unsigned HC_D  = TABLE_SIZE * KEY_MAX;
  localparam int unsigned HC_AW = $clog2(HC_D);
  localparam int unsigned SC_D  = SPILL_SIZE * KEY_MAX;
  localparam int unsigned SC_AW = (SC_D > 1) ? $clog2(SC_D) : 1;
  localparam int unsigned HM_W  = 1 + LEN_W + LNK_W;
  localparam int unsigned SM_W  = LEN_W + LNK_W;
  localparam int unsigned CNT_W = (LEN_W > BKT_W) ? LEN_W : BKT_W;
  localparam int unsigned OB_W  = (BKT_W > 4) ? BKT_W : 4;
  localparam logic [LNK_W-1:0] NO_LINK = '1;

  // residue of every character code modulo the table size
  function automatic logic [256*BKT_W-1:0] res_table();
    logic [256*BKT_W-1:0] t;
    t = '0;
    for (int i = 0; i < 256; i++) begin
      t[i*BKT_W +: BKT_W] = BKT_W'(i % TABLE_SIZE);
    end
    return t;
  endfunction

  localparam logic [256*BKT_W-1:0] RES_TAB = res_table();

  // sequencer states
  localparam logic [4:0] S_CLEAR     = 5'd0;
  localparam logic [4:0] S_IDLE      = 5'd1;
  localparam logic [4:0] S_HM_RD     = 5'd3;
  localparam logic [4:0] S_HM_WAIT   = 5'd4;
  localparam logic [4:0] S_CMP_START = 5'd5;
  localparam logic [4:0] S_CMP_RD    = 5'd6;
  localparam logic [4:0] S_CMP_CHK   = 5'd7;
  localparam logic [4:0] S_EVAL      = 5'd8;
  localparam logic [4:0] S_SM_RD     = 5'd9;
  localparam logic [4:0] S_SM_WAIT   = 5'd10;
  localparam logic [4:0] S_FOUND     = 5'd11;
  localparam logic [4:0] S_DEL_RD    = 5'd12;
  localparam logic [4:0] S_DEL_WAIT  = 5'd13;
  localparam logic [4:0] S_DEL_FIN   = 5'd14;
  localparam logic [4:0] S_COPY      = 5'd15;
  localparam logic [4:0] S_INS_LINK  = 5'd16;
  localparam logic [4:0] S_IW_RD     = 5'd17;
  localparam logic [4:0] S_IW_WAIT   = 5'd18;
  localparam logic [4:0] S_DONE      = 5'd19;

  logic [4:0]        state_q, state_d;
  logic [LEN_W-1:0]  key_len_q, key_len_d;
  logic              overlong_q, overlong_d;
  logic [1:0]        op_q, op_d;
  logic [BKT_W:0]    rem_q, rem_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [LEN_W-1:0]  h_len_q, h_len_d;
  logic [LNK_W-1:0]  h_link_q, h_link_d;
  logic [LEN_W-1:0]  s_len_q, s_len_d;
  logic [LNK_W-1:0]  s_link_q, s_link_d;
  logic [SP_W-1:0]   p_q, p_d;
  logic [SP_W-1:0]   prev_q, prev_d;
  logic [LEN_W-1:0]  prev_len_q, prev_len_d;
  logic              prev_none_q, prev_none_d;
  logic              cmp_spill_q, cmp_spill_d;
  logic              match_q, match_d;
  logic [SP_W-1:0]   slot_q, slot_d;
  logic [LNK_W-1:0]  used_q, used_d;
  logic              cp_src_spill_q, cp_src_spill_d;
  logic              cp_dst_spill_q, cp_dst_spill_d;
  logic [LEN_W-1:0]  cp_len_q, cp_len_d;
  logic [4:0]        cp_next_q, cp_next_d;
  logic [2:0]        status_q, status_d;
  logic              out_valid_q, out_valid_d;
  cht_pkg::cht_out_t out_data_q, out_data_d;

  // memory ports
  logic              kb_we;
  logic [7:0]        kb_rdata;
  logic              hc_we;
  logic [HC_AW-1:0]  hc_waddr, hc_raddr;
  logic [7:0]        hc_rdata;
  logic              sc_we;
  logic [SC_AW-1:0]  sc_waddr, sc_raddr;
  logic [7:0]        sc_rdata;
  logic [7:0]        cp_wdata;
  logic              hm_we;
  logic [BKT_W-1:0]  hm_waddr;
  logic [HM_W-1:0]   hm_wdata, hm_rdata;
  logic              sm_we;
  logic [SP_W-1:0]   sm_waddr;
  logic [SM_W-1:0]   sm_wdata, sm_rdata;

  logic              in_fire;
  logic [BKT_W-1:0]  bkt;
  logic [KI_W-1:0]   rd_idx;
  logic [CNT_W-1:0]  wr_cnt;
  logic [BKT_W:0]    rem_add;
  logic [LEN_W-1:0]  cmp_len;
  logic [7:0]        cmp_char;
  logic              hm_valid;
  logic [LEN_W-1:0]  hm_len, sm_len;
  logic [LNK_W-1:0]  hm_link, sm_link;
  logic [OB_W-1:0]   bkt_ext;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i & in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  assign bkt       = rem_q[BKT_W-1:0];
  assign bkt_ext   = OB_W'(bkt);
  assign rd_idx    = cnt_q[KI_W-1:0];
  assign wr_cnt    = cnt_q - CNT_W'(1);
  assign rem_add   = rem_q + {1'b0, RES_TAB[32'(in_data_i.key_char) * BKT_W +: BKT_W]};

  assign hm_valid = hm_rdata[HM_W-1];
  assign hm_len   = hm_rdata[LNK_W +: LEN_W];
  assign hm_link  = hm_rdata[LNK_W-1:0];
  assign sm_len   = sm_rdata[LNK_W +: LEN_W];
  assign sm_link  = sm_rdata[LNK_W-1:0];

  assign cmp_len  = cmp_spill_q ? s_len_q : h_len_q;
  assign cmp_char = cmp_spill_q ? sc_rdata : hc_rdata;
  assign cp_wdata = cp_src_spill_q ? sc_rdata : kb_rdata;

  // character addresses: entry * KEY_MAX + index
  assign hc_raddr = HC_AW'(32'(bkt) * KEY_MAX + 32'(cnt_q));
  assign sc_raddr = SC_AW'(32'(p_q) * KEY_MAX + 32'(cnt_q));
  assign hc_waddr = HC_AW'(32'(bkt) * KEY_MAX + 32'(wr_cnt));
  assign sc_waddr = SC_AW'(32'(slot_q) * KEY_MAX + 32'(wr_cnt));

  assign kb_we = in_fire && (key_len_q < LEN_W'(KEY_MAX));

  always_comb begin
    state_d        = state_q;
    key_len_d      = key_len_q;
    overlong_d     = overlong_q;
    op_d           = op_q;
    rem_d          = rem_q;
    cnt_d          = cnt_q;
    h_len_d        = h_len_q;
    h_link_d       = h_link_q;
    s_len_d        = s_len_q;
    s_link_d       = s_link_q;
    p_d            = p_q;
    prev_d         = prev_q;
    prev_len_d     = prev_len_q;
    prev_none_d    = prev_none_q;
    cmp_spill_d    = cmp_spill_q;
    match_d        = match_q;
    slot_d         = slot_q;
    used_d         = used_q;
    cp_src_spill_d = cp_src_spill_q;
    cp_dst_spill_d = cp_dst_spill_q;
    cp_len_d       = cp_len_q;
    cp_next_d      = cp_next_q;
    status_d       = status_q;
    out_valid_d    = out_valid_q & ~out_ready_i;
    out_data_d     = out_data_q;

    hc_we    = 1'b0;
    sc_we    = 1'b0;
    hm_we    = 1'b0;
    hm_waddr = bkt;
    hm_wdata = {1'b1, h_len_q, h_link_q};
    sm_we    = 1'b0;
    sm_waddr = p_q;
    sm_wdata = {s_len_q, s_link_q};

    case (state_q)
      S_CLEAR: begin
        // mark every bucket empty
        hm_we    = 1'b1;
        hm_waddr = cnt_q[BKT_W-1:0];
        hm_wdata = '0;
        cnt_d    = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(TABLE_SIZE - 1)) begin
          cnt_d   = '0;
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          if (key_len_q < LEN_W'(KEY_MAX)) begin
            key_len_d = key_len_q + LEN_W'(1);
            // running sum modulo the table size
            if (rem_add >= (BKT_W + 1)'(TABLE_SIZE)) begin
              rem_d = rem_add - (BKT_W + 1)'(TABLE_SIZE);
            end else begin
              rem_d = rem_add;
            end
          end else begin
            overlong_d = 1'b1;
          end
          if (in_data_i.last_char) begin
            op_d  = in_data_i.opcode;
            cnt_d = '0;
            if (overlong_d) begin
              status_d = cht_pkg::STAT_TOO_LONG;
              state_d  = S_DONE;
            end else begin
              state_d = S_HM_RD;
            end
          end
        end
      end
      S_HM_RD: begin
        state_d = S_HM_WAIT;
      end
      S_HM_WAIT: begin
        h_len_d  = hm_len;
        h_link_d = hm_link;
        if (op_q == cht_pkg::OP_INSERT) begin
          status_d       = cht_pkg::STAT_INSERTED;
          cp_src_spill_d = 1'b0;
          cp_len_d       = key_len_q;
          cnt_d          = '0;
          if (!hm_valid) begin
            // empty bucket takes the key as its primary entry
            hm_we          = 1'b1;
            hm_wdata       = {1'b1, key_len_q, NO_LINK};
            cp_dst_spill_d = 1'b0;
            cp_next_d      = S_DONE;
            state_d        = S_COPY;
          end else if (used_q >= LNK_W'(SPILL_SIZE)) begin
            status_d = cht_pkg::STAT_FULL;
            state_d  = S_DONE;
          end else begin
            // next free overflow slot, then append it to the chain
            sm_we          = 1'b1;
            sm_waddr       = used_q[SP_W-1:0];
            sm_wdata       = {key_len_q, NO_LINK};
            slot_d         = used_q[SP_W-1:0];
            used_d         = used_q + LNK_W'(1);
            cp_dst_spill_d = 1'b1;
            cp_next_d      = S_INS_LINK;
            state_d        = S_COPY;
          end
        end else if (!hm_valid) begin
          status_d = cht_pkg::STAT_NOT_FOUND;
          state_d  = S_DONE;
        end else begin
          cmp_spill_d = 1'b0;
          state_d     = S_CMP_START;
        end
      end
      S_CMP_START: begin
        cnt_d = '0;
        if (cmp_len != key_len_q) begin
          match_d = 1'b0;
          state_d = S_EVAL;
        end else begin
          state_d = S_CMP_RD;
        end
      end
      S_CMP_RD: begin
        state_d = S_CMP_CHK;
      end
      S_CMP_CHK: begin
        if (kb_rdata != cmp_char) begin
          match_d = 1'b0;
          state_d = S_EVAL;
        end else if (cnt_q == CNT_W'(cmp_len - LEN_W'(1))) begin
          match_d = 1'b1;
          state_d = S_EVAL;
        end else begin
          cnt_d   = cnt_q + CNT_W'(1);
          state_d = S_CMP_RD;
        end
      end
      S_EVAL: begin
        if (match_q) begin
          state_d = S_FOUND;
        end else if (!cmp_spill_q) begin
          if (h_link_q < LNK_W'(SPILL_SIZE)) begin
            prev_none_d = 1'b1;
            p_d         = h_link_q[SP_W-1:0];
            state_d     = S_SM_RD;
          end else begin
            status_d = cht_pkg::STAT_NOT_FOUND;
            state_d  = S_DONE;
          end
        end else begin
          if (s_link_q < LNK_W'(SPILL_SIZE)) begin
            prev_none_d = 1'b0;
            prev_d      = p_q;
            prev_len_d  = s_len_q;
            p_d         = s_link_q[SP_W-1:0];
            state_d     = S_SM_RD;
          end else begin
            status_d = cht_pkg::STAT_NOT_FOUND;
            state_d  = S_DONE;
          end
        end
      end
      S_SM_RD: begin
        state_d = S_SM_WAIT;
      end
      S_SM_WAIT: begin
        s_len_d     = sm_len;
        s_link_d    = sm_link;
        cmp_spill_d = 1'b1;
        state_d     = S_CMP_START;
      end
      S_FOUND: begin
        if (op_q != cht_pkg::OP_DELETE) begin
          status_d = cht_pkg::STAT_FOUND;
          state_d  = S_DONE;
        end else begin
          status_d = cht_pkg::STAT_DELETED;
          if (!cmp_spill_q) begin
            if (h_link_q < LNK_W'(SPILL_SIZE)) begin
              // successor moves into the primary entry
              p_d     = h_link_q[SP_W-1:0];
              state_d = S_DEL_RD;
            end else begin
              hm_we    = 1'b1;
              hm_wdata = '0;
              state_d  = S_DONE;
            end
          end else if (prev_none_q) begin
            hm_we    = 1'b1;
            hm_wdata = {1'b1, h_len_q, s_link_q};
            state_d  = S_DONE;
          end else begin
            sm_we    = 1'b1;
            sm_waddr = prev_q;
            sm_wdata = {prev_len_q, s_link_q};
            state_d  = S_DONE;
          end
        end
      end
      S_DEL_RD: begin
        state_d = S_DEL_WAIT;
      end
      S_DEL_WAIT: begin
        s_len_d        = sm_len;
        s_link_d       = sm_link;
        cp_src_spill_d = 1'b1;
        cp_dst_spill_d = 1'b0;
        cp_len_d       = sm_len;
        cp_next_d      = S_DEL_FIN;
        cnt_d          = '0;
        state_d        = S_COPY;
      end
      S_DEL_FIN: begin
        hm_we    = 1'b1;
        hm_wdata = {1'b1, s_len_q, s_link_q};
        state_d  = S_DONE;
      end
      S_COPY: begin
        // read index cnt, write index cnt-1 from the data read last cycle
        if (cnt_q != '0) begin
          hc_we = ~cp_dst_spill_q;
          sc_we = cp_dst_spill_q;
        end
        if (cnt_q == CNT_W'(cp_len_q)) begin
          cnt_d   = '0;
          state_d = cp_next_q;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      S_INS_LINK: begin
        if (h_link_q < LNK_W'(SPILL_SIZE)) begin
          p_d     = h_link_q[SP_W-1:0];
          state_d = S_IW_RD;
        end else begin
          hm_we    = 1'b1;
          hm_wdata = {1'b1, h_len_q, LNK_W'(slot_q)};
          state_d  = S_DONE;
        end
      end
      S_IW_RD: begin
        state_d = S_IW_WAIT;
      end
      S_IW_WAIT: begin
        if (sm_link < LNK_W'(SPILL_SIZE)) begin
          p_d     = sm_link[SP_W-1:0];
          state_d = S_IW_RD;
        end else begin
          // chain tail points at the new slot
          sm_we    = 1'b1;
          sm_wdata = {sm_len, LNK_W'(slot_q)};
          state_d  = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d       = 1'b1;
          out_data_d.status = status_q;
          out_data_d.bucket = bkt_ext[3:0];
          key_len_d         = '0;
          rem_d             = '0;
          overlong_d        = 1'b0;
          state_d           = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      key_len_q   <= '0;
      rem_q       <= '0;
      overlong_q  <= 1'b0;
      cnt_q       <= '0;
      used_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      key_len_q   <= key_len_d;
      rem_q       <= rem_d;
      overlong_q  <= overlong_d;
      cnt_q       <= cnt_d;
      used_q      <= used_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q           <= op_d;
    h_len_q        <= h_len_d;
    h_link_q       <= h_link_d;
    s_len_q        <= s_len_d;
    s_link_q       <= s_link_d;
    p_q            <= p_d;
    prev_q         <= prev_d;
    prev_len_q     <= prev_len_d;
    prev_none_q    <= prev_none_d;
    cmp_spill_q    <= cmp_spill_d;
    match_q        <= match_d;
    slot_q         <= slot_d;
    cp_src_spill_q <= cp_src_spill_d;
    cp_dst_spill_q <= cp_dst_spill_d;
    cp_len_q       <= cp_len_d;
    cp_next_q      <= cp_next_d;
    status_q       <= status_d;
    out_data_q     <= out_data_d;
  end

  // key characters of the key in flight
  cht_ram #(.WIDTH(8), .DEPTH(KEY_MAX)) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (kb_we),
    .waddr_i (key_len_q[KI_W-1:0]),
    .wdata_i (in_data_i.key_char),
    .raddr_i (rd_idx),
    .rdata_o (kb_rdata)
  );

  // primary entry characters, one row of KEY_MAX per bucket
  cht_ram #(.WIDTH(8), .DEPTH(HC_D)) u_head_chars (
    .clk_i   (clk_i),
    .we_i    (hc_we),
    .waddr_i (hc_waddr),
    .wdata_i (cp_wdata),
    .raddr_i (hc_raddr),
    .rdata_o (hc_rdata)
  );

  // overflow entry characters
  cht_ram #(.WIDTH(8), .DEPTH(SC_D)) u_spill_chars (
    .clk_i   (clk_i),
    .we_i    (sc_we),
    .waddr_i (sc_waddr),
    .wdata_i (cp_wdata),
    .raddr_i (sc_raddr),
    .rdata_o (sc_rdata)
  );

  // bucket valid, primary length and link
  cht_ram #(.WIDTH(HM_W), .DEPTH(TABLE_SIZE)) u_head_meta (
    .clk_i   (clk_i),
    .we_i    (hm_we),
    .waddr_i (hm_waddr),
    .wdata_i (hm_wdata),
    .raddr_i (bkt),
    .rdata_o (hm_rdata)
  );

  // overflow length and link
  cht_ram #(.WIDTH(SM_W), .DEPTH(SPILL_SIZE)) u_spill_meta (
    .clk_i   (clk_i),
    .we_i    (sm_we),
    .waddr_i (sm_waddr),
    .wdata_i (sm_wdata),
    .raddr_i (p_q),
    .rdata_o (sm_rdata)
  );

endmodule

// ===== rtl/cht_ram.sv =====
module cht_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== verif/tb_chained_hash_table.sv =====
module tb_chained_hash_table;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TSIZE = cht_pkg::DefTableSize;
  localparam int KMAX = cht_pkg::DefKeyMax;
  localparam int SSIZE = cht_pkg::DefSpillSize;
  localparam int NONE = -1;
  localparam int IDLE_LIMIT = 20000;
  localparam int RAND_ITEMS = 1200;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  cht_pkg::cht_in_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  cht_pkg::cht_out_t out_data_o;

  chained_hash_table dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // shadow table state
  logic [7:0] key_chars[KMAX];
  int key_len, key_sum;
  bit key_over;
  bit slot_valid[TSIZE];
  logic [7:0] head_key[TSIZE][KMAX];
  int head_len[TSIZE], head_next[TSIZE];
  logic [7:0] spill_key[SSIZE][KMAX];
  int spill_len[SSIZE], spill_next[SSIZE];
  int spill_fill;

  cht_pkg::cht_out_t expected_results[$];
  int err_count = 0;
  bit quiet = 1'b0;          // no idling on either side while set
  int sent_items = 0;
  logic [7:0] key_pool[$][$];

  function automatic bit is_link(int p);
    return p >= 0 && p < SSIZE;
  endfunction

  function automatic bit head_match(int b);
    if (head_len[b] != key_len) return 1'b0;
    for (int i = 0; i < key_len; i++) if (head_key[b][i] != key_chars[i]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic bit spill_match(int p);
    if (spill_len[p] != key_len) return 1'b0;
    for (int i = 0; i < key_len; i++) if (spill_key[p][i] != key_chars[i]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic bit chain_find(int b);
    int p;
    if (!slot_valid[b]) return 1'b0;
    if (head_match(b)) return 1'b1;
    p = head_next[b];
    for (int s = 0; s < SSIZE && is_link(p); s++) begin
      if (spill_match(p)) return 1'b1;
      p = spill_next[p];
    end
    return 1'b0;
  endfunction

  function automatic logic [2:0] chain_insert(int b);
    int slot, p;
    if (!slot_valid[b]) begin
      for (int i = 0; i < key_len; i++) head_key[b][i] = key_chars[i];
      head_len[b] = key_len;
      head_next[b] = NONE;
      slot_valid[b] = 1'b1;
      return cht_pkg::STAT_INSERTED;
    end
    if (spill_fill >= SSIZE) return cht_pkg::STAT_FULL;
    slot = spill_fill;
    for (int i = 0; i < key_len; i++) spill_key[slot][i] = key_chars[i];
    spill_len[slot] = key_len;
    spill_next[slot] = NONE;
    spill_fill++;
    if (!is_link(head_next[b])) begin
      head_next[b] = slot;
    end else begin
      p = head_next[b];
      for (int s = 0; s < SSIZE && is_link(spill_next[p]); s++) p = spill_next[p];
      spill_next[p] = slot;
    end
    return cht_pkg::STAT_INSERTED;
  endfunction

  function automatic void chain_unlink(int b);
    int p, prev;
    if (!is_link(head_next[b])) begin
      slot_valid[b] = 1'b0;
      return;
    end
    if (head_match(b)) begin
      p = head_next[b];
      for (int i = 0; i < KMAX; i++) head_key[b][i] = spill_key[p][i];
      head_len[b] = spill_len[p];
      head_next[b] = spill_next[p];
      return;
    end
    prev = NONE;
    p = head_next[b];
    for (int s = 0; s < SSIZE && is_link(p); s++) begin
      if (spill_match(p)) begin
        if (!is_link(prev)) head_next[b] = spill_next[p];
        else spill_next[prev] = spill_next[p];
        return;
      end
      prev = p;
      p = spill_next[p];
    end
  endfunction

  // advance the shadow table by one accepted character
  function automatic void table_apply(cht_pkg::cht_in_t d);
    cht_pkg::cht_out_t r;
    int b;
    if (key_len < KMAX) begin
      key_chars[key_len] = d.key_char;
      key_len++;
      key_sum += d.key_char;
    end else begin
      key_over = 1'b1;
    end
    if (!d.last_char) return;
    b = key_sum % TSIZE;
    if (key_over) r.status = cht_pkg::STAT_TOO_LONG;
    else if (d.opcode == cht_pkg::OP_INSERT) r.status = chain_insert(b);
    else if (d.opcode == cht_pkg::OP_DELETE) begin
      if (chain_find(b)) begin
        chain_unlink(b);
        r.status = cht_pkg::STAT_DELETED;
      end else begin
        r.status = cht_pkg::STAT_NOT_FOUND;
      end
    end else r.status = chain_find(b) ? cht_pkg::STAT_FOUND : cht_pkg::STAT_NOT_FOUND;
    r.bucket = b[3:0];
    expected_results.push_back(r);
    key_len = 0;
    key_sum = 0;
    key_over = 1'b0;
  endfunction

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic report_mismatch(string msg);
    err_count++;
    $display("mismatch @%0t: %s", $realtime, msg);
  endtask

  // one transfer on the input channel; called at a rising edge
  task automatic send_char(logic [1:0] op, logic [7:0] ch, logic last);
    cht_pkg::cht_in_t d;
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    d.opcode = op;
    d.key_char = ch;
    d.last_char = last;
    in_valid_i <= 1'b1;
    in_data_i <= d;
    do @(posedge clk_i); while (!in_ready_o);
    table_apply(d);
    sent_items++;
  endtask

  // earlier characters get a random opcode; only the last one counts
  task automatic send_key(logic [1:0] op, logic [7:0] k[$]);
    for (int i = 0; i < k.size(); i++)
      send_char(i == k.size() - 1 ? op : 2'($urandom_range(0, 3)), k[i], i == k.size() - 1);
  endtask

  task automatic wait_drained();
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_basic_ops();
    quiet = 1'b1;
    send_key(cht_pkg::OP_SEARCH, '{8'h41});          // empty bucket
    send_key(cht_pkg::OP_INSERT, '{8'h41});
    send_key(cht_pkg::OP_INSERT, '{8'h41});          // duplicate goes to the chain
    send_key(cht_pkg::OP_INSERT, '{8'h31, 8'h10});   // same bucket, different key
    send_key(cht_pkg::OP_SEARCH, '{8'h31, 8'h10});
    send_key(cht_pkg::OP_ALIAS, '{8'h41});           // code three acts as search
    quiet = 1'b0;
    send_key(cht_pkg::OP_DELETE, '{8'h41});          // head replaced by successor
    send_key(cht_pkg::OP_DELETE, '{8'h31, 8'h10});   // chain entry unlinked
    send_key(cht_pkg::OP_DELETE, '{8'h77});          // delete not found
    send_key(cht_pkg::OP_INSERT, '{8'h00, 8'hff});   // zero and max codes
    send_key(cht_pkg::OP_SEARCH, '{8'hff, 8'h00});   // same sum, different order
    send_key(cht_pkg::OP_DELETE, '{8'h00, 8'hff});   // lone head, bucket emptied
  endtask

  task automatic test_long_keys();
    logic [7:0] k[$];
    k = {};
    for (int i = 0; i < KMAX; i++) k.push_back(8'hff);
    send_key(cht_pkg::OP_INSERT, k);                 // exactly the limit
    send_key(cht_pkg::OP_SEARCH, k);
    k.push_back(8'h01);
    send_key(cht_pkg::OP_INSERT, k);                 // one over, too long
    k = {};
    for (int i = 0; i < KMAX + 4; i++) k.push_back(8'($urandom_range(0, 255)));
    send_key(cht_pkg::OP_DELETE, k);
  endtask

  task automatic random_key(output logic [7:0] k[$]);
    int r, len;
    k = {};
    if (key_pool.size() != 0 && $urandom_range(0, 1)) begin
      k = key_pool[$urandom_range(0, key_pool.size() - 1)];
      return;
    end
    r = $urandom_range(0, 99);
    if (r < 85) len = $urandom_range(1, 3);
    else if (r < 95) len = $urandom_range(4, KMAX);
    else len = $urandom_range(KMAX + 1, KMAX + 3);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) < 8) k.push_back(8'($urandom_range(0, 3) * 16 + 1));
      else k.push_back(8'($urandom_range(0, 255)));
    end
    if (len <= KMAX) key_pool.push_back(k);
  endtask

  task automatic test_random_traffic();
    logic [7:0] k[$];
    int r, start;
    logic [1:0] op;
    start = sent_items;
    while (sent_items - start < RAND_ITEMS) begin
      random_key(k);
      r = $urandom_range(0, 99);
      if (r < 35) op = cht_pkg::OP_INSERT;
      else if (r < 65) op = cht_pkg::OP_SEARCH;
      else if (r < 95) op = cht_pkg::OP_DELETE;
      else op = cht_pkg::OP_ALIAS;
      quiet = (sent_items / 200) % 4 == 3;
      send_key(op, k);
      if ($urandom_range(0, 99) == 0) begin
        in_valid_i <= 1'b0;
        wait_drained();
      end
    end
    quiet = 1'b0;
  endtask

  task automatic test_overflow_full();
    // keep adding to one bucket until the spill area runs out
    for (int i = 0; i < SSIZE + 2; i++) send_key(cht_pkg::OP_INSERT, '{8'h05});
    send_key(cht_pkg::OP_SEARCH, '{8'h05});
    send_key(cht_pkg::OP_DELETE, '{8'h05});
  endtask

  // result channel: back-pressure with random stalls
  int stall_left = 0;
  always @(posedge clk_i) begin
    if (quiet) begin
      out_ready_i <= 1'b1;
      stall_left = 0;
    end else if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left--;
    end else begin
      out_ready_i <= 1'b1;
      if ($urandom_range(0, 99) < 25)
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    cht_pkg::cht_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result %0d/%0d",
                        out_data_o.status, out_data_o.bucket));
      end else begin
        want = expected_results.pop_front();
        if (out_data_o.status !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", out_data_o.status, want.status));
        if (out_data_o.bucket !== want.bucket)
          report_mismatch($sformatf("bucket %0d, want %0d", out_data_o.bucket, want.bucket));
      end
    end
  end

  // watchdog on cycles with no transfer at all
  int idle_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    key_len = 0;
    key_sum = 0;
    key_over = 1'b0;
    spill_fill = 0;
    for (int b = 0; b < TSIZE; b++) begin
      slot_valid[b] = 1'b0;
      head_len[b] = 0;
      head_next[b] = 0;
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_basic_ops();
    test_long_keys();
    in_valid_i <= 1'b0;
    wait_drained();
    test_random_traffic();
    test_overflow_full();
    in_valid_i <= 1'b0;
    wait_drained();
    repeat (200) @(posedge clk_i);
    if (expected_results.size() != 0) report_mismatch("results still outstanding");
    if (err_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
